/* design/picture_unit_cpu_register_port_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the picture unit CPU register port
// Shared wrappers for clocked concurrent assertions, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef PICTURE_UNIT_CPU_REGISTER_PORT_CORE_MACROS_SVH
`define PICTURE_UNIT_CPU_REGISTER_PORT_CORE_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define PUCRP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a condition that must hold on every rising clock edge, reset included
`define PUCRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pucrp_pkg.sv */
// ----------------------------------------------------------------------------
// pucrp_pkg
// Types and constants of the picture unit CPU register port.
// ----------------------------------------------------------------------------
package pucrp_pkg;

    // Kind of access carried on the input channel
    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_DMA    = 2'd3
    } action_t;

    // Register index within the eight-byte mirrored window
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPR_AD = 3'd3;
    localparam logic [2:0] REG_SPR_DT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_VADDR  = 3'd6;
    localparam logic [2:0] REG_VDATA  = 3'd7;

    localparam logic [15:0] DMA_PAGE_ADDR = 16'h4014;
    localparam logic [2:0]  REG_WINDOW    = 3'b001;   // addr[15:13] of 0x2000-0x3FFF
    localparam logic [7:0]  PALETTE_PAGE  = 8'h3F;
    localparam logic [7:0]  STATUS_RD_MSK = 8'hE0;
    localparam logic [7:0]  STATUS_KEEP   = 8'h60;
    localparam logic [7:0]  VADDR_HI_MSK  = 8'h3F;
    localparam logic [15:0] VSTEP_ROW     = 16'd32;
    localparam logic [15:0] VSTEP_COL     = 16'd1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;

    // One result word, plus a flag that the sprite memory supplies read_data
    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] vram_address;
        logic        vram_read;
        logic        vram_write;
        logic [7:0]  vram_wdata;
        logic        dma_valid;
        logic [15:0] dma_source;
        logic [7:0]  ctrl_value;
        logic [7:0]  mask_value;
        logic [7:0]  scroll_x;
        logic [7:0]  scroll_y;
        logic        spr_read;
    } res_t;

endpackage

/* design/picture_unit_cpu_register_port_core.sv */
// ----------------------------------------------------------------------------
// picture_unit_cpu_register_port_core
// CPU-facing register file of a picture unit: ctrl, mask, status, sprite
// memory, scroll pair, video address and DMA page sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the action
//   (read, write, status load, DMA step) and s_tdata the address and bytes.
//   Each accepted word yields exactly one result word on m_tvalid/m_tready.
//   Each word passes the middle stage, which applies the register update and
//   issues the sprite memory read, then the output register, which holds the
//   result with the returned registered memory data merged in.
//   Throughput is one word per cycle while m_tready is high; the sprite memory
//   has one write and one read port, and each word touches at most one entry.
//   When the receiver stalls, the output register holds its word and the
//   middle stage fills; s_tready drops only once both are occupied.
//   Reset (aresetn low, synchronous) clears the state registers, empties the
//   pipeline and marks every sprite entry as unwritten (reads return 0),
//   so no clearing pass is needed and words are taken the cycle after.
// ----------------------------------------------------------------------------
`include "picture_unit_cpu_register_port_core_macros.svh"

module picture_unit_cpu_register_port_core import pucrp_pkg::*; #(
    parameter int SPRITE_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] cpu_addr, [23:16] cpu_data, [31:24] vram_data, [39:32] status_in
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_data, [23:8] vram_address, [24] vram_read, [25] vram_write,
    // [33:26] vram_wdata, [34] dma_valid, [50:35] dma_source,
    // [58:51] ctrl_value, [66:59] mask_value, [74:67] scroll_x,
    // [82:75] scroll_y, [87:83] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SPR_AW = $clog2(SPRITE_BYTES);

    // Architectural registers
    logic [7:0]  ctrl_reg,     ctrl_next;
    logic [7:0]  mask_reg,     mask_next;
    logic [7:0]  status_reg,   status_next;
    logic [7:0]  spr_ptr_reg,  spr_ptr_next;
    logic        toggle_reg,   toggle_next;
    logic [7:0]  sx_reg,       sx_next;
    logic [7:0]  sy_reg,       sy_next;
    logic        latch_reg,    latch_next;
    logic [15:0] vptr_reg,     vptr_next;
    logic [7:0]  rbuf_reg,     rbuf_next;
    logic        dma_busy_reg, dma_busy_next;
    logic [15:0] dma_ptr_reg,  dma_ptr_next;

    // Pipeline
    res_t s1_reg, out_reg, res0, res1;
    logic s1_valid_reg, out_valid_reg;
    logic advance, accept;

    // Input fields
    action_t     action;
    logic [15:0] cpu_addr;
    logic [7:0]  cpu_data, vram_data, status_in;
    logic        in_regs;
    logic [2:0]  reg_idx;
    logic [15:0] vstep;
    logic        spr_we, spr_re;
    logic [7:0]  spr_rdata;

    assign action    = action_t'(s_tuser);
    assign cpu_addr  = s_tdata[15:0];
    assign cpu_data  = s_tdata[23:16];
    assign vram_data = s_tdata[31:24];
    assign status_in = s_tdata[39:32];
    assign in_regs   = (cpu_addr[15:13] == REG_WINDOW);
    assign reg_idx   = cpu_addr[2:0];
    assign vstep     = ctrl_reg[2] ? VSTEP_ROW : VSTEP_COL;

    // Handshake: middle stage moves on when the output register frees up
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Decode one word: next register values and the result fields
    always_comb begin
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        spr_ptr_next  = spr_ptr_reg;
        toggle_next   = toggle_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        latch_next    = latch_reg;
        vptr_next     = vptr_reg;
        rbuf_next     = rbuf_reg;
        dma_busy_next = dma_busy_reg;
        dma_ptr_next  = dma_ptr_reg;
        res0          = '0;
        spr_we        = 1'b0;
        spr_re        = 1'b0;
        case (action)
            ACT_READ: begin
                if (in_regs) begin
                    case (reg_idx)
                        REG_STATUS: begin
                            res0.read_data = status_reg & STATUS_RD_MSK;
                            status_next    = status_reg & STATUS_KEEP;
                            latch_next     = 1'b0;
                        end
                        REG_SPR_DT: begin
                            res0.spr_read = 1'b1;
                            spr_re        = 1'b1;
                            spr_ptr_next  = spr_ptr_reg + 8'd1;
                        end
                        REG_VDATA: begin
                            res0.read_data    = (vptr_reg[15:8] == PALETTE_PAGE) ?
                                                vram_data : rbuf_reg;
                            rbuf_next         = vram_data;
                            res0.vram_address = vptr_reg;
                            res0.vram_read    = 1'b1;
                            vptr_next         = vptr_reg + vstep;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_WRITE: begin
                if (cpu_addr == DMA_PAGE_ADDR) begin
                    dma_busy_next = 1'b1;
                    dma_ptr_next  = {cpu_data, 8'd0};
                end else if (in_regs) begin
                    case (reg_idx)
                        REG_CTRL:   ctrl_next    = cpu_data;
                        REG_MASK:   mask_next    = cpu_data;
                        REG_SPR_AD: spr_ptr_next = cpu_data;
                        REG_SPR_DT: begin
                            spr_we       = 1'b1;
                            spr_ptr_next = spr_ptr_reg + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (!toggle_reg) begin
                                sx_next = cpu_data;
                            end else begin
                                sy_next = cpu_data;
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_VADDR: begin
                            if (!latch_reg) begin
                                vptr_next = {cpu_data & VADDR_HI_MSK, 8'd0};
                            end else begin
                                vptr_next = {vptr_reg[15:8], cpu_data};
                            end
                            latch_next = !latch_reg;
                        end
                        REG_VDATA: begin
                            res0.vram_address = vptr_reg;
                            res0.vram_write   = 1'b1;
                            res0.vram_wdata   = cpu_data;
                            vptr_next         = vptr_reg + vstep;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_STATUS: begin
                status_next = status_in;
            end
            ACT_DMA: begin
                if (dma_busy_reg) begin
                    res0.dma_valid  = 1'b1;
                    res0.dma_source = dma_ptr_reg;
                    dma_ptr_next    = dma_ptr_reg + 16'd1;
                    if (dma_ptr_next[7:0] == 8'd0) begin
                        dma_busy_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        res0.ctrl_value = ctrl_next;
        res0.mask_value = mask_next;
        res0.scroll_x   = sx_next;
        res0.scroll_y   = sy_next;
    end

    // Commit register updates on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= '0;
            mask_reg     <= '0;
            status_reg   <= '0;
            spr_ptr_reg  <= '0;
            toggle_reg   <= 1'b0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            latch_reg    <= 1'b0;
            vptr_reg     <= '0;
            rbuf_reg     <= '0;
            dma_busy_reg <= 1'b0;
            dma_ptr_reg  <= '0;
        end else if (accept) begin
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            spr_ptr_reg  <= spr_ptr_next;
            toggle_reg   <= toggle_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            latch_reg    <= latch_next;
            vptr_reg     <= vptr_next;
            rbuf_reg     <= rbuf_next;
            dma_busy_reg <= dma_busy_next;
            dma_ptr_reg  <= dma_ptr_next;
        end
    end

    // Sprite memory: one entry per word, read data returns next cycle
    pucrp_spr_ram #(
        .DEPTH (SPRITE_BYTES),
        .AW    (SPR_AW)
    ) u_spr_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (accept && spr_we),
        .waddr   (spr_ptr_reg[SPR_AW-1:0]),
        .wdata   (cpu_data),
        .re      (accept && spr_re),
        .raddr   (spr_ptr_reg[SPR_AW-1:0]),
        .rdata   (spr_rdata)
    );

    // Merge the returned sprite byte into the middle-stage word
    always_comb begin
        res1 = s1_reg;
        if (s1_reg.spr_read) begin
            res1.read_data = spr_rdata;
        end
        res1.spr_read = 1'b0;
    end

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= res0;
        end
        if (advance && s1_valid_reg) begin
            out_reg <= res1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.scroll_y, out_reg.scroll_x, out_reg.mask_value,
                       out_reg.ctrl_value, out_reg.dma_source, out_reg.dma_valid,
                       out_reg.vram_wdata, out_reg.vram_write, out_reg.vram_read,
                       out_reg.vram_address, out_reg.read_data};

    // Back-pressure only when the middle stage is occupied
    `PUCRP_ASSERT(a_ready_only_when_full, aclk, aresetn,
        !s_tready |-> s1_valid_reg, "input stalled with empty middle stage")
    // A DMA page write starts the transfer
    `PUCRP_ASSERT(a_dma_start, aclk, aresetn,
        (accept && action == ACT_WRITE && cpu_addr == DMA_PAGE_ADDR) |=> dma_busy_reg,
        "DMA page write did not start transfer")
    // A status read clears the vblank flag and the address latch
    `PUCRP_ASSERT(a_status_read_clears, aclk, aresetn,
        (accept && action == ACT_READ && in_regs && reg_idx == REG_STATUS)
            |=> (!latch_reg && !status_reg[7]),
        "status read did not clear flag and latch")
    // A result never reads and writes video memory at once
    `PUCRP_ASSERT(a_vram_exclusive, aclk, aresetn,
        out_valid_reg |-> !(out_reg.vram_read && out_reg.vram_write),
        "video memory read and write in one result")

endmodule

/* design/pucrp_spr_ram.sv */
// ----------------------------------------------------------------------------
// pucrp_spr_ram
// Sprite attribute memory: one write and one registered read per cycle,
// with per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module pucrp_spr_ram import pucrp_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_reg;
    logic             rd_valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_reg <= mem[raddr];
        end
    end

    // Track written entries; reset makes every entry read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : 8'd0;

endmodule
